// ===== rtl/core/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared constants, types and helpers of the multilevel feedback queue
// scheduler: slot table row layout, link encoding, opcodes, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	localparam int SLOTS      = 64;
	localparam int MAX_LEVELS = 8;

	localparam int SLOT_W    = 6;
	localparam int LVL_W     = 3;
	localparam int QL_W      = 3;
	localparam int OP_W      = 3;
	localparam int RS_W      = 2;
	localparam int LVREG_W   = 4;
	localparam int WAIT_W    = 16;
	localparam int SLICE_W   = 5;
	localparam int TICK_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int LCNT_W    = $clog2(MAX_LEVELS + 1);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int LINK_W    = SLOT_W + 1;

	typedef logic [SLOT_W-1:0]            slot_t;
	typedef logic [LVL_W-1:0]             lvl_t;
	typedef logic [LINK_W-1:0]            link_t;
	typedef logic [MAX_LEVELS*TICK_W-1:0] tick_row_t;

	localparam link_t LINK_NULL = '1;

	// opcodes
	localparam logic [OP_W-1:0] OP_SET     = 3'd0;
	localparam logic [OP_W-1:0] OP_PICK    = 3'd1;
	localparam logic [OP_W-1:0] OP_RUN     = 3'd2;
	localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;

	// run states
	localparam logic [RS_W-1:0] RS_UNUSED = 2'd0;
	localparam logic [RS_W-1:0] RS_SLEEP  = 2'd1;
	localparam logic [RS_W-1:0] RS_RUN    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR    = 2'd2;

	// one slot table entry
	typedef struct packed {
		logic                blk;
		logic [RS_W-1:0]     rs;
		lvl_t                level;
		logic [WAIT_W-1:0]   wait_cnt;
		logic [SLICE_W-1:0]  slice_cnt;
	} row_t;

	// controller to datapath
	typedef struct packed {
		logic      srd_en;
		slot_t     srd_addr;
		logic      swr_en;
		slot_t     swr_addr;
		row_t      swr_data;
		logic      lrd_en;
		slot_t     lrd_addr;
		logic      nwr_en;
		slot_t     nwr_addr;
		link_t     nwr_data;
		logic      pwr_en;
		slot_t     pwr_addr;
		link_t     pwr_data;
		lvl_t      hl_lv;
		logic      hwr_en;
		link_t     hwr_data;
		logic      twr_en;
		link_t     twr_data;
		logic      qclr_all;
		logic      q_en;
		slot_t     q_addr;
		logic      q_val;
		logic      trd_en;
		slot_t     trd_addr;
		logic      tkw_en;
		logic      tkclr_en;
		slot_t     tkw_addr;
		tick_row_t tkw_data;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		row_t      row;
		logic      queued;
		link_t     lnext;
		link_t     lprev;
		link_t     head;
		link_t     tail;
		tick_row_t trow;
	} dp_sts_t;

	function automatic logic link_ok(input link_t l);
		return l < LINK_W'(SLOTS);
	endfunction

	function automatic logic eligible(input row_t r);
		return (r.rs == RS_RUN) && !r.blk;
	endfunction

endpackage

// ===== rtl/core/mlfq_if.sv =====
// ----------------------------------------------------------------------------
// mlfq_if
// Valid/ready channels of the scheduler: the operation channel and the
// result channel.
// ----------------------------------------------------------------------------
interface mlfq_in_if import mlfq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	slot_t            slot;
	logic [RS_W-1:0]  run_state;
	logic             blocked;
	logic [QL_W-1:0]  query_level;

	modport source(output valid, output opcode, output slot, output run_state,
		output blocked, output query_level, input ready);
	modport sink(input valid, input opcode, input slot, input run_state,
		input blocked, input query_level, output ready);
endinterface

interface mlfq_out_if import mlfq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              found;
	slot_t             picked_slot;
	lvl_t              picked_level;
	logic [TICK_W-1:0] tick_value;

	modport source(output valid, output found, output picked_slot,
		output picked_level, output tick_value, input ready);
	modport sink(input valid, input found, input picked_slot,
		input picked_level, input tick_value, output ready);
endinterface

// ===== rtl/core/mlfq_dpath.sv =====
// ----------------------------------------------------------------------------
// mlfq_dpath
// Scheduler storage: slot table, queue link memories, per-slot tick rows,
// queue head/tail registers and queued flags. Executes the controller's
// read/write commands; all memory reads are registered.
// ----------------------------------------------------------------------------
module mlfq_dpath import mlfq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  dp_cmd_t cmd,
	output dp_sts_t sts
);

	row_t       slot_mem_q [SLOTS];
	link_t      next_mem_q [SLOTS];
	link_t      prev_mem_q [SLOTS];
	tick_row_t  tick_mem_q [SLOTS];
	link_t      head_q     [MAX_LEVELS];
	link_t      tail_q     [MAX_LEVELS];
	logic [SLOTS-1:0] slot_vld_q;
	logic [SLOTS-1:0] tick_vld_q;
	logic [SLOTS-1:0] queued_q;

	row_t      row_rd_q;
	logic      queued_rd_q;
	link_t     lnext_rd_q;
	link_t     lprev_rd_q;
	tick_row_t trow_rd_q;

	// memories, registered read ports; a slot or tick entry never written reads as zero
	always_ff @(posedge clk) begin
		if (cmd.swr_en) begin
			slot_mem_q[cmd.swr_addr] <= cmd.swr_data;
		end
		if (cmd.srd_en) begin
			row_rd_q    <= slot_vld_q[cmd.srd_addr] ? slot_mem_q[cmd.srd_addr] : '0;
			queued_rd_q <= queued_q[cmd.srd_addr];
		end
		if (cmd.nwr_en) begin
			next_mem_q[cmd.nwr_addr] <= cmd.nwr_data;
		end
		if (cmd.pwr_en) begin
			prev_mem_q[cmd.pwr_addr] <= cmd.pwr_data;
		end
		if (cmd.lrd_en) begin
			lnext_rd_q <= next_mem_q[cmd.lrd_addr];
			lprev_rd_q <= prev_mem_q[cmd.lrd_addr];
		end
		if (cmd.tkw_en) begin
			tick_mem_q[cmd.tkw_addr] <= cmd.tkw_data;
		end
		if (cmd.trd_en) begin
			trow_rd_q <= tick_vld_q[cmd.trd_addr] ? tick_mem_q[cmd.trd_addr] : '0;
		end
	end

	// valid bits, queued flags and queue ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			tick_vld_q <= '0;
			queued_q   <= '0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				head_q[i] <= LINK_NULL;
				tail_q[i] <= LINK_NULL;
			end
		end else begin
			if (cmd.swr_en) begin
				slot_vld_q[cmd.swr_addr] <= 1'b1;
			end
			if (cmd.tkw_en) begin
				tick_vld_q[cmd.tkw_addr] <= 1'b1;
			end
			if (cmd.tkclr_en) begin
				tick_vld_q[cmd.tkw_addr] <= 1'b0;
			end
			if (cmd.q_en) begin
				queued_q[cmd.q_addr] <= cmd.q_val;
			end
			if (cmd.hwr_en) begin
				head_q[cmd.hl_lv] <= cmd.hwr_data;
			end
			if (cmd.twr_en) begin
				tail_q[cmd.hl_lv] <= cmd.twr_data;
			end
			if (cmd.qclr_all) begin
				queued_q <= '0;
				for (int i = 0; i < MAX_LEVELS; i++) begin
					head_q[i] <= LINK_NULL;
					tail_q[i] <= LINK_NULL;
				end
			end
		end
	end

	assign sts.row    = row_rd_q;
	assign sts.queued = queued_rd_q;
	assign sts.lnext  = lnext_rd_q;
	assign sts.lprev  = lprev_rd_q;
	assign sts.head   = head_q[cmd.hl_lv];
	assign sts.tail   = tail_q[cmd.hl_lv];
	assign sts.trow   = trow_rd_q;

endmodule

// ===== rtl/core/mlfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Scheduler sequencer: decodes an operation, walks the slot table and the
// level queues one entry at a time, issues datapath commands and holds the
// result register of the output channel. Also holds the mode registers.
// ----------------------------------------------------------------------------
module mlfq_ctrl import mlfq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	mlfq_in_if.sink              in_ch,
	mlfq_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output dp_cmd_t              cmd,
	input  dp_sts_t              sts
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_START  = 5'd1;
	localparam logic [4:0] ST_SET1   = 5'd2;
	localparam logic [4:0] ST_SETCLR = 5'd3;
	localparam logic [4:0] ST_UNL1   = 5'd4;
	localparam logic [4:0] ST_PU1    = 5'd5;
	localparam logic [4:0] ST_PU2    = 5'd6;
	localparam logic [4:0] ST_RR0    = 5'd7;
	localparam logic [4:0] ST_RR1    = 5'd8;
	localparam logic [4:0] ST_E0     = 5'd9;
	localparam logic [4:0] ST_E1     = 5'd10;
	localparam logic [4:0] ST_E2     = 5'd11;
	localparam logic [4:0] ST_A0     = 5'd12;
	localparam logic [4:0] ST_A1     = 5'd13;
	localparam logic [4:0] ST_A2     = 5'd14;
	localparam logic [4:0] ST_AP     = 5'd15;
	localparam logic [4:0] ST_A3     = 5'd16;
	localparam logic [4:0] ST_D0     = 5'd17;
	localparam logic [4:0] ST_D1     = 5'd18;
	localparam logic [4:0] ST_D2     = 5'd19;
	localparam logic [4:0] ST_RF1    = 5'd20;
	localparam logic [4:0] ST_RD1    = 5'd21;
	localparam logic [4:0] ST_DONE   = 5'd22;

	logic [4:0]         state_q;
	logic [OP_W-1:0]    op_q;
	slot_t              slot_q;
	logic [RS_W-1:0]    rs_q;
	logic               bl_q;
	logic [QL_W-1:0]    ql_q;

	logic               prio_q;
	logic [LVREG_W-1:0] levels_q;
	logic [WAIT_W-1:0]  thr_q;

	slot_t              rot_q;
	slot_t              cur_q;
	slot_t              k_q;
	slot_t              idx_q;
	logic [LCNT_W-1:0]  lv_q;
	link_t              node_q;
	link_t              nxt_q;
	logic [CNT_W-1:0]   guard_q;
	lvl_t               ulv_q;
	slot_t              unode_q;
	logic [4:0]         uret_q;
	slot_t              pnode_q;
	lvl_t               plv_q;
	logic [4:0]         pret_q;
	link_t              ptail_q;

	logic               res_found_q;
	slot_t              res_slot_q;
	lvl_t               res_level_q;
	logic [TICK_W-1:0]  res_tick_q;
	logic               out_valid_q;
	logic               out_found_q;
	slot_t              out_slot_q;
	lvl_t               out_level_q;
	logic [TICK_W-1:0]  out_tick_q;

	logic               in_fire;
	logic               slot_ok;
	logic               ql_ok;
	logic [LCNT_W-1:0]  l_eff;
	lvl_t               l_half;
	logic [WAIT_W-1:0]  thr_eff;
	logic               elig_row;
	logic               walk_go;
	logic [WAIT_W-1:0]  wait_inc;
	logic               age_hit;
	lvl_t               rf_lv;
	logic [LCNT_W-1:0]  rf_lv_p1;
	logic [SLICE_W-1:0] rf_slice1;
	logic               rf_demote;
	logic               rf_active;
	lvl_t               rf_lv_new;
	logic [SLICE_W-1:0] rf_slice_new;
	tick_row_t          rf_trow;
	slot_t              cur_wrap;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.found        = out_found_q;
	assign out_ch.picked_slot  = out_slot_q;
	assign out_ch.picked_level = out_level_q;
	assign out_ch.tick_value   = out_tick_q;

	// operand checks and effective register values
	assign slot_ok = CNT_W'(slot_q) < CNT_W'(SLOTS);
	assign ql_ok   = LCNT_W'(ql_q) < LCNT_W'(MAX_LEVELS);
	assign thr_eff = (thr_q == '0) ? WAIT_W'(1) : thr_q;
	assign l_half  = lvl_t'(l_eff >> 1);

	always_comb begin
		if (levels_q == '0) begin
			l_eff = LCNT_W'(1);
		end else if (int'(levels_q) > MAX_LEVELS) begin
			l_eff = LCNT_W'(MAX_LEVELS);
		end else begin
			l_eff = LCNT_W'(levels_q);
		end
	end

	// walk and aging helpers
	assign elig_row = eligible(sts.row);
	assign walk_go  = link_ok(node_q) && (guard_q != CNT_W'(SLOTS));
	assign wait_inc = (sts.row.wait_cnt == '1) ? sts.row.wait_cnt
		: sts.row.wait_cnt + 1'b1;
	assign age_hit  = wait_inc >= thr_eff;
	assign cur_wrap = (cur_q == SLOT_W'(SLOTS - 1)) ? '0 : cur_q + 1'b1;

	// run-finished slice accounting
	assign rf_lv        = sts.row.level;
	assign rf_lv_p1     = LCNT_W'(rf_lv) + 1'b1;
	assign rf_slice1    = sts.row.slice_cnt + 1'b1;
	assign rf_demote    = rf_slice1 >= SLICE_W'({rf_lv_p1, 1'b0});
	assign rf_active    = (sts.row.rs == RS_RUN) || (sts.row.rs == RS_SLEEP);
	assign rf_lv_new    = (rf_demote && (rf_lv_p1 < l_eff)) ? lvl_t'(rf_lv_p1) : rf_lv;
	assign rf_slice_new = rf_demote ? '0 : rf_slice1;

	always_comb begin
		rf_trow = sts.trow;
		rf_trow[rf_lv*TICK_W +: TICK_W] = sts.trow[rf_lv*TICK_W +: TICK_W] + 1'b1;
	end

	// datapath commands
	always_comb begin
		row_t r;
		r = sts.row;
		cmd = '0;
		cmd.hl_lv = lv_q[LVL_W-1:0];
		unique case (state_q)
			ST_START: begin
				unique case (op_q)
					OP_SET: begin
						cmd.srd_en   = slot_ok;
						cmd.srd_addr = slot_q;
					end
					OP_RUN: begin
						cmd.srd_en   = slot_ok && prio_q;
						cmd.srd_addr = slot_q;
						cmd.trd_en   = slot_ok && prio_q;
						cmd.trd_addr = slot_q;
					end
					OP_RESTART: cmd.qclr_all = 1'b1;
					OP_READ: begin
						cmd.trd_en   = slot_ok && ql_ok;
						cmd.trd_addr = slot_q;
					end
					default: ;
				endcase
			end
			ST_SET1: begin
				if (rs_q == RS_UNUSED) begin
					cmd.lrd_en   = sts.queued;
					cmd.lrd_addr = slot_q;
				end else begin
					r.rs         = rs_q;
					r.blk        = bl_q;
					cmd.swr_en   = 1'b1;
					cmd.swr_addr = slot_q;
					cmd.swr_data = r;
				end
			end
			ST_SETCLR: begin
				cmd.swr_en   = 1'b1;
				cmd.swr_addr = slot_q;
				cmd.swr_data = '0;
				cmd.q_en     = 1'b1;
				cmd.q_addr   = slot_q;
				cmd.q_val    = 1'b0;
				cmd.tkclr_en = 1'b1;
				cmd.tkw_addr = slot_q;
			end
			// unlink from level ulv using the links read last
			ST_UNL1: begin
				cmd.hl_lv = ulv_q;
				if (link_ok(sts.lprev)) begin
					cmd.nwr_en   = 1'b1;
					cmd.nwr_addr = sts.lprev[SLOT_W-1:0];
					cmd.nwr_data = sts.lnext;
				end else begin
					cmd.hwr_en   = 1'b1;
					cmd.hwr_data = sts.lnext;
				end
				if (link_ok(sts.lnext)) begin
					cmd.pwr_en   = 1'b1;
					cmd.pwr_addr = sts.lnext[SLOT_W-1:0];
					cmd.pwr_data = sts.lprev;
				end else begin
					cmd.twr_en   = 1'b1;
					cmd.twr_data = sts.lprev;
				end
				cmd.q_en   = 1'b1;
				cmd.q_addr = unode_q;
				cmd.q_val  = 1'b0;
			end
			// append at the tail of level plv
			ST_PU1: begin
				cmd.hl_lv    = plv_q;
				cmd.nwr_en   = 1'b1;
				cmd.nwr_addr = pnode_q;
				cmd.nwr_data = LINK_NULL;
				cmd.pwr_en   = 1'b1;
				cmd.pwr_addr = pnode_q;
				cmd.pwr_data = sts.tail;
				cmd.twr_en   = 1'b1;
				cmd.twr_data = link_t'({1'b0, pnode_q});
				cmd.hwr_en   = !link_ok(sts.tail);
				cmd.hwr_data = link_t'({1'b0, pnode_q});
				cmd.q_en     = 1'b1;
				cmd.q_addr   = pnode_q;
				cmd.q_val    = 1'b1;
			end
			ST_PU2: begin
				cmd.nwr_en   = link_ok(ptail_q);
				cmd.nwr_addr = ptail_q[SLOT_W-1:0];
				cmd.nwr_data = link_t'({1'b0, pnode_q});
			end
			ST_RR0: begin
				cmd.srd_en   = 1'b1;
				cmd.srd_addr = cur_q;
			end
			ST_E0: begin
				cmd.srd_en   = 1'b1;
				cmd.srd_addr = idx_q;
			end
			ST_E1: begin
				r.level      = l_half;
				cmd.swr_en   = elig_row && !sts.queued;
				cmd.swr_addr = idx_q;
				cmd.swr_data = r;
			end
			ST_A1, ST_D1: begin
				cmd.srd_en   = walk_go;
				cmd.srd_addr = node_q[SLOT_W-1:0];
				cmd.lrd_en   = walk_go;
				cmd.lrd_addr = node_q[SLOT_W-1:0];
			end
			ST_A2: begin
				if (age_hit) begin
					r.level     = lvl_t'(lv_q - 1'b1);
					r.wait_cnt  = '0;
					r.slice_cnt = '0;
				end else begin
					r.wait_cnt  = wait_inc;
				end
				cmd.swr_en   = 1'b1;
				cmd.swr_addr = node_q[SLOT_W-1:0];
				cmd.swr_data = r;
			end
			ST_D2: begin
				r.wait_cnt   = '0;
				cmd.swr_en   = elig_row;
				cmd.swr_addr = node_q[SLOT_W-1:0];
				cmd.swr_data = r;
			end
			ST_RF1: begin
				r.level      = rf_lv_new;
				r.slice_cnt  = rf_slice_new;
				cmd.swr_en   = rf_active;
				cmd.swr_addr = slot_q;
				cmd.swr_data = r;
				cmd.tkw_en   = rf_active;
				cmd.tkw_addr = slot_q;
				cmd.tkw_data = rf_trow;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_SET;
			slot_q      <= '0;
			rs_q        <= RS_UNUSED;
			bl_q        <= 1'b0;
			ql_q        <= '0;
			prio_q      <= 1'b0;
			levels_q    <= LVREG_W'(1);
			thr_q       <= WAIT_W'(1);
			rot_q       <= '0;
			cur_q       <= '0;
			k_q         <= '0;
			idx_q       <= '0;
			lv_q        <= '0;
			node_q      <= LINK_NULL;
			nxt_q       <= LINK_NULL;
			guard_q     <= '0;
			ulv_q       <= '0;
			unode_q     <= '0;
			uret_q      <= ST_IDLE;
			pnode_q     <= '0;
			plv_q       <= '0;
			pret_q      <= ST_IDLE;
			ptail_q     <= LINK_NULL;
			res_found_q <= 1'b0;
			res_slot_q  <= '0;
			res_level_q <= '0;
			res_tick_q  <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_slot_q  <= '0;
			out_level_q <= '0;
			out_tick_q  <= '0;
		end else begin
			// register writes
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_MODE:   prio_q   <= cfg_wdata[0];
					CFG_LEVELS: levels_q <= cfg_wdata[LVREG_W-1:0];
					CFG_THR:    thr_q    <= cfg_wdata[WAIT_W-1:0];
					default: ;
				endcase
			end

			// completion reloads the result register itself
			if (out_ch.valid && out_ch.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q    <= in_ch.opcode;
						slot_q  <= in_ch.slot;
						rs_q    <= in_ch.run_state;
						bl_q    <= in_ch.blocked;
						ql_q    <= in_ch.query_level;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					res_found_q <= 1'b0;
					res_slot_q  <= '0;
					res_level_q <= '0;
					res_tick_q  <= '0;
					unique case (op_q)
						OP_SET:  state_q <= slot_ok ? ST_SET1 : ST_DONE;
						OP_PICK: begin
							if (prio_q) begin
								idx_q   <= '0;
								state_q <= ST_E0;
							end else begin
								cur_q   <= rot_q;
								k_q     <= '0;
								state_q <= ST_RR0;
							end
						end
						OP_RUN:  state_q <= (slot_ok && prio_q) ? ST_RF1 : ST_DONE;
						OP_READ: state_q <= (slot_ok && ql_ok) ? ST_RD1 : ST_DONE;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_SET1: begin
					if (rs_q == RS_UNUSED) begin
						if (sts.queued) begin
							ulv_q   <= sts.row.level;
							unode_q <= slot_q;
							uret_q  <= ST_SETCLR;
							state_q <= ST_UNL1;
						end else begin
							state_q <= ST_SETCLR;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SETCLR: state_q <= ST_DONE;
				ST_UNL1:   state_q <= uret_q;
				ST_PU1: begin
					ptail_q <= sts.tail;
					state_q <= ST_PU2;
				end
				ST_PU2: state_q <= pret_q;
				// round robin: each slot is read in RR0 and checked in RR1
				ST_RR0: state_q <= ST_RR1;
				ST_RR1: begin
					if (elig_row) begin
						res_found_q <= 1'b1;
						res_slot_q  <= cur_q;
						res_level_q <= sts.row.level;
						rot_q       <= cur_wrap;
						state_q     <= ST_DONE;
					end else if (k_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						cur_q   <= cur_wrap;
						k_q     <= k_q + 1'b1;
						state_q <= ST_RR0;
					end
				end
				// enqueue sweep over all slots
				ST_E0: state_q <= ST_E1;
				ST_E1: begin
					if (elig_row && !sts.queued) begin
						pnode_q <= idx_q;
						plv_q   <= l_half;
						pret_q  <= ST_E2;
						state_q <= ST_PU1;
					end else begin
						state_q <= ST_E2;
					end
				end
				ST_E2: begin
					if (idx_q == SLOT_W'(SLOTS - 1)) begin
						lv_q    <= LCNT_W'(1);
						state_q <= ST_A0;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_E0;
					end
				end
				// aging walk over levels 1 and up
				ST_A0: begin
					if (lv_q >= l_eff) begin
						lv_q    <= '0;
						state_q <= ST_D0;
					end else begin
						node_q  <= sts.head;
						guard_q <= '0;
						state_q <= ST_A1;
					end
				end
				ST_A1: begin
					if (walk_go) begin
						state_q <= ST_A2;
					end else begin
						lv_q    <= lv_q + 1'b1;
						state_q <= ST_A0;
					end
				end
				ST_A2: begin
					nxt_q <= sts.lnext;
					if (age_hit) begin
						ulv_q   <= lv_q[LVL_W-1:0];
						unode_q <= node_q[SLOT_W-1:0];
						uret_q  <= ST_AP;
						state_q <= ST_UNL1;
					end else begin
						state_q <= ST_A3;
					end
				end
				ST_AP: begin
					pnode_q <= node_q[SLOT_W-1:0];
					plv_q   <= lvl_t'(lv_q - 1'b1);
					pret_q  <= ST_A3;
					state_q <= ST_PU1;
				end
				ST_A3: begin
					node_q  <= nxt_q;
					guard_q <= guard_q + 1'b1;
					state_q <= ST_A1;
				end
				// dequeue scan from the top level
				ST_D0: begin
					if (lv_q >= l_eff) begin
						state_q <= ST_DONE;
					end else begin
						node_q  <= sts.head;
						guard_q <= '0;
						state_q <= ST_D1;
					end
				end
				ST_D1: begin
					if (walk_go) begin
						state_q <= ST_D2;
					end else begin
						lv_q    <= lv_q + 1'b1;
						state_q <= ST_D0;
					end
				end
				ST_D2: begin
					if (elig_row) begin
						res_found_q <= 1'b1;
						res_slot_q  <= node_q[SLOT_W-1:0];
						res_level_q <= sts.row.level;
						ulv_q       <= lv_q[LVL_W-1:0];
						unode_q     <= node_q[SLOT_W-1:0];
						uret_q      <= ST_DONE;
						state_q     <= ST_UNL1;
					end else begin
						node_q  <= sts.lnext;
						guard_q <= guard_q + 1'b1;
						state_q <= ST_D1;
					end
				end
				ST_RF1: begin
					if (rf_active && elig_row && !sts.queued) begin
						pnode_q <= slot_q;
						plv_q   <= rf_lv_new;
						pret_q  <= ST_DONE;
						state_q <= ST_PU1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RD1: begin
					res_tick_q <= sts.trow[ql_q*TICK_W +: TICK_W];
					state_q    <= ST_DONE;
				end
				// hand the result to the output register
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_found_q <= res_found_q;
						out_slot_q  <= res_slot_q;
						out_level_q <= res_level_q;
						out_tick_q  <= res_tick_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_START)
		else $error("accepted operation did not start");

	a_guard_bound: assert property (@(posedge clk) disable iff (!arst_n)
		guard_q <= CNT_W'(SLOTS))
		else $error("queue walk ran past the slot count");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside completion");

endmodule

// ===== rtl/core/mlfq_scheduler_with_aging.sv =====
// ----------------------------------------------------------------------------
// mlfq_scheduler_with_aging
// Multilevel feedback queue scheduler with aging over a table of process
// slots; round-robin or priority picking, slice accounting and tick reads.
// ----------------------------------------------------------------------------
// Round-robin pick examines one slot at a time from the rotation point.
// Priority pick runs an enqueue sweep over all slots, an aging walk over the
// queue entries of levels 1 and up and a dequeue scan from the top level; one
// slot table port sets the pace. One operation is in flight at a time.
// Reset clears all state at once through per-slot valid bits; no sweep.
// ----------------------------------------------------------------------------
module mlfq_scheduler_with_aging import mlfq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	mlfq_in_if.sink              in_ch,
	mlfq_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	mlfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	mlfq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ===== test/tb_mlfq_scheduler_with_aging.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mlfq_scheduler_with_aging
// Self-checking bench for the multilevel feedback queue scheduler. A queue
// of operations feeds a clocked driver; an in-bench scheduler model predicts
// every result at the input transfer and a clocked monitor compares each
// output transfer field by field. Phases sweep mode, level count and aging
// threshold (extremes included) under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_mlfq_scheduler_with_aging;
	import mlfq_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam logic [RS_W-1:0] RS_OTHER    = 2'd3;
	localparam int NIL = -1;
	localparam longint CYCLE_LIMIT = 20_000_000;

	typedef struct packed {
		logic [OP_W-1:0] op;
		slot_t           slot;
		logic [RS_W-1:0] rs;
		logic            blk;
		logic [QL_W-1:0] ql;
	} sched_op_t;

	typedef struct packed {
		logic              found;
		slot_t             slot;
		lvl_t              level;
		logic [TICK_W-1:0] ticks;
	} sched_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_MODE;
	logic [CFG_W-1:0] cfg_wdata = '0;

	mlfq_in_if  in_ch();
	mlfq_out_if out_ch();

	mlfq_scheduler_with_aging dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	sched_op_t  pending_ops[$];
	sched_res_t expected_results[$];
	int idle_mode = 0;
	int mismatches = 0;
	longint cycles = 0;

	// scheduler model state
	logic            m_prio;
	logic [3:0]      m_levels;
	logic [15:0]     m_thr;
	logic [1:0]      m_rs[SLOTS];
	logic            m_blk[SLOTS];
	logic            m_queued[SLOTS];
	int              m_lvl[SLOTS];
	logic [15:0]     m_wait[SLOTS];
	logic [4:0]      m_slice[SLOTS];
	logic [31:0]     m_ticks[SLOTS*MAX_LEVELS];
	int              m_next[SLOTS];
	int              m_prev[SLOTS];
	int              m_head[MAX_LEVELS];
	int              m_tail[MAX_LEVELS];
	int              m_rot;

	function automatic bit runnable(int s);
		return m_rs[s] == RS_RUN && !m_blk[s];
	endfunction

	function automatic int level_count();
		int l;
		l = m_levels;
		if (l == 0) l = 1;
		if (l > MAX_LEVELS) l = MAX_LEVELS;
		return l;
	endfunction

	task automatic queue_append(int lv, int s);
		int t;
		t = m_tail[lv];
		m_next[s] = NIL;
		m_prev[s] = t;
		if (t >= 0) m_next[t] = s;
		else m_head[lv] = s;
		m_tail[lv] = s;
		m_queued[s] = 1;
	endtask

	task automatic queue_remove(int lv, int s);
		int p, n;
		p = m_prev[s];
		n = m_next[s];
		if (p >= 0) m_next[p] = n; else m_head[lv] = n;
		if (n >= 0) m_prev[n] = p; else m_tail[lv] = p;
		m_queued[s] = 0;
	endtask

	task automatic flush_queues();
		for (int i = 0; i < MAX_LEVELS; i++) begin
			m_head[i] = NIL;
			m_tail[i] = NIL;
		end
		for (int s = 0; s < SLOTS; s++) m_queued[s] = 0;
	endtask

	task automatic sched_reset();
		m_prio = 0;
		m_levels = 1;
		m_thr = 1;
		for (int s = 0; s < SLOTS; s++) begin
			m_rs[s] = RS_UNUSED;
			m_blk[s] = 0;
			m_lvl[s] = 0;
			m_wait[s] = 0;
			m_slice[s] = 0;
			m_next[s] = NIL;
			m_prev[s] = NIL;
		end
		for (int i = 0; i < SLOTS*MAX_LEVELS; i++) m_ticks[i] = 0;
		flush_queues();
		m_rot = 0;
	endtask

	// priority pick: enqueue newcomers, age, then dequeue from the top level
	task automatic pick_priority(output bit hit, output int chosen);
		int L, node, nxt, thr;
		L = level_count();
		thr = (m_thr == 0) ? 1 : m_thr;
		hit = 0;
		chosen = 0;
		for (int s = 0; s < SLOTS; s++)
			if (runnable(s) && !m_queued[s]) begin
				m_lvl[s] = L / 2;
				queue_append(L / 2, s);
			end
		for (int i = 1; i < L; i++) begin
			node = m_head[i];
			for (int g = 0; node >= 0 && g < SLOTS; g++) begin
				nxt = m_next[node];
				if (m_wait[node] != 16'hFFFF) m_wait[node]++;
				if (m_wait[node] >= thr) begin
					queue_remove(i, node);
					m_lvl[node] = i - 1;
					m_wait[node] = 0;
					m_slice[node] = 0;
					queue_append(i - 1, node);
				end
				node = nxt;
			end
		end
		for (int i = 0; i < L && !hit; i++) begin
			node = m_head[i];
			for (int g = 0; node >= 0 && g < SLOTS && !hit; g++) begin
				if (runnable(node)) begin
					queue_remove(i, node);
					m_wait[node] = 0;
					chosen = node;
					hit = 1;
				end else
					node = m_next[node];
			end
		end
	endtask

	// expected result of one operation, updating the model
	task automatic sched_apply(input sched_op_t o, output sched_res_t r);
		int s, lv, chosen;
		bit hit;
		s = o.slot;
		r = '0;
		case (o.op)
			OP_SET: begin
				if (o.rs == RS_UNUSED) begin
					if (m_queued[s]) queue_remove(m_lvl[s], s);
					m_rs[s] = RS_UNUSED;
					m_blk[s] = 0;
					m_lvl[s] = 0;
					m_wait[s] = 0;
					m_slice[s] = 0;
					for (int i = 0; i < MAX_LEVELS; i++) m_ticks[s*MAX_LEVELS+i] = 0;
				end else begin
					m_rs[s] = o.rs;
					m_blk[s] = o.blk;
				end
			end
			OP_PICK: begin
				hit = 0;
				chosen = 0;
				if (m_prio) pick_priority(hit, chosen);
				else begin
					for (int k = 0; k < SLOTS && !hit; k++)
						if (runnable((m_rot + k) % SLOTS)) begin
							chosen = (m_rot + k) % SLOTS;
							m_rot = (chosen + 1) % SLOTS;
							hit = 1;
						end
				end
				if (hit) begin
					r.found = 1;
					r.slot = slot_t'(chosen);
					r.level = lvl_t'(m_lvl[chosen]);
				end
			end
			OP_RUN: begin
				// slices only counted in priority mode, for slots in the run or sleep state
				if (m_prio && (m_rs[s] == RS_RUN || m_rs[s] == RS_SLEEP)) begin
					lv = m_lvl[s];
					m_slice[s]++;
					m_ticks[s*MAX_LEVELS+lv]++;
					if (m_slice[s] >= 2 * (lv + 1)) begin
						if (lv + 1 < level_count()) m_lvl[s] = lv + 1;
						m_slice[s] = 0;
					end
					if (runnable(s) && !m_queued[s]) queue_append(m_lvl[s], s);
				end
			end
			OP_RESTART: flush_queues();
			OP_READ: r.ticks = m_ticks[s*MAX_LEVELS+o.ql];
			default: ;
		endcase
	endtask

	// input driver; an offered operation stays put until its transfer
	always @(posedge clk) begin
		sched_res_t r;
		int idle_pct;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				sched_apply(pending_ops[0], r);
				expected_results.push_back(r);
				void'(pending_ops.pop_front());
			end
			if (!in_ch.valid || in_ch.ready) begin
				idle_pct = (idle_mode == 1) ? 85 : (idle_mode == 3) ? 14 : 0;
				if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_ch.valid <= 1;
					in_ch.opcode <= pending_ops[0].op;
					in_ch.slot <= pending_ops[0].slot;
					in_ch.run_state <= pending_ops[0].rs;
					in_ch.blocked <= pending_ops[0].blk;
					in_ch.query_level <= pending_ops[0].ql;
				end else
					in_ch.valid <= 0;
			end
		end
	end

	// output monitor and receiver stalls
	always @(posedge clk) begin
		sched_res_t got, want;
		int stall_pct;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.found, out_ch.picked_slot, out_ch.picked_level, out_ch.tick_value};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got.found !== want.found || got.slot !== want.slot ||
					got.level !== want.level || got.ticks !== want.ticks) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p got %p", want, got);
				end
			end
		end
		stall_pct = (idle_mode == 2) ? 85 : (idle_mode == 3) ? 14 : 0;
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk)
		if (cycles > CYCLE_LIMIT) begin
			$display("** mlfq_scheduler_with_aging: FAILED **");
			$finish;
		end

	function automatic sched_op_t make_op(logic [OP_W-1:0] op, int s, int rs, int blk, int ql);
		sched_op_t o;
		o.op = op;
		o.slot = slot_t'(s);
		o.rs = rs[RS_W-1:0];
		o.blk = blk[0];
		o.ql = ql[QL_W-1:0];
		return o;
	endfunction

	// random operation, slots mostly from a small working set
	function automatic sched_op_t random_op();
		int p, s, rsel, rs;
		logic [OP_W-1:0] op;
		p = $urandom_range(99);
		if (p < 35) op = OP_SET;
		else if (p < 65) op = OP_PICK;
		else if (p < 85) op = OP_RUN;
		else if (p < 88) op = OP_RESTART;
		else if (p < 98) op = OP_READ;
		else op = OP_OP_SPARE();
		s = ($urandom_range(9) < 7) ? $urandom_range(11) : $urandom_range(SLOTS - 1);
		rsel = $urandom_range(99);
		rs = (rsel < 8) ? RS_UNUSED : (rsel < 25) ? RS_SLEEP : (rsel < 85) ? RS_RUN : RS_OTHER;
		return make_op(op, s, rs, ($urandom_range(9) < 2), $urandom_range(7));
	endfunction

	function automatic logic [OP_W-1:0] OP_OP_SPARE();
		return OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
	endfunction

	task automatic wait_drained();
		while (pending_ops.size() != 0 || expected_results.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_MODE) m_prio = val[0];
		else if (idx == CFG_LEVELS) m_levels = val[3:0];
		else if (idx == CFG_THR) m_thr = val;
		@(posedge clk);
	endtask

	// per-phase settings: mode, level count, aging threshold
	int ph_mode[7] = '{0, 1, 1, 1, 1, 1, 0};
	int ph_lvls[7] = '{1, 8, 0, 15, 4, 2, 8};
	int ph_thr[7]  = '{1, 1, 3, 0, 65535, 2, 5};

	initial begin
		in_ch.valid = 0;
		in_ch.opcode = OP_SET;
		in_ch.slot = '0;
		in_ch.run_state = RS_UNUSED;
		in_ch.blocked = 0;
		in_ch.query_level = '0;
		out_ch.ready = 0;
		sched_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int ph = 0; ph < 7; ph++) begin
			idle_mode = ph % 4;
			write_reg(CFG_MODE, CFG_W'(ph_mode[ph]));
			write_reg(CFG_LEVELS, CFG_W'(ph_lvls[ph]));
			write_reg(CFG_THR, CFG_W'(ph_thr[ph]));
			if (ph == 0 || ph == 1) begin
				// directed: extremes, every opcode, every run state
				pending_ops.push_back(make_op(OP_PICK, 0, 0, 0, 0));
				pending_ops.push_back(make_op(OP_SET, 63, RS_RUN, 0, 0));
				pending_ops.push_back(make_op(OP_SET, 0, RS_RUN, 0, 0));
				pending_ops.push_back(make_op(OP_SET, 1, RS_RUN, 1, 0));
				pending_ops.push_back(make_op(OP_SET, 2, RS_SLEEP, 0, 0));
				pending_ops.push_back(make_op(OP_SET, 3, RS_OTHER, 1, 7));
				for (int k = 0; k < 3; k++) pending_ops.push_back(make_op(OP_PICK, 0, 0, 0, 0));
				for (int k = 0; k < 4; k++) pending_ops.push_back(make_op(OP_RUN, 63, 0, 0, 0));
				pending_ops.push_back(make_op(OP_RUN, 2, 0, 0, 0));
				pending_ops.push_back(make_op(OP_RUN, 3, 0, 0, 0));
				pending_ops.push_back(make_op(OP_READ, 63, 0, 0, 0));
				pending_ops.push_back(make_op(OP_READ, 63, 0, 0, 7));
				pending_ops.push_back(make_op(OP_READ, 2, 0, 0, 4));
				pending_ops.push_back(make_op(OP_SET, 63, RS_UNUSED, 1, 0));
				pending_ops.push_back(make_op(OP_READ, 63, 0, 0, 0));
				pending_ops.push_back(make_op(OP_RESTART, 0, 0, 0, 0));
				pending_ops.push_back(make_op(OP_PICK, 0, 0, 0, 0));
				pending_ops.push_back(make_op(OP_SPARE_LO, 5, 3, 1, 7));
				pending_ops.push_back(make_op(OP_SPARE_HI, 63, 2, 0, 3));
			end
			for (int k = 0; k < 90; k++) pending_ops.push_back(random_op());
			// hold the sender once until everything has come back
			if (ph == 2) wait_drained();
			for (int k = 0; k < 90; k++) pending_ops.push_back(random_op());
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("** mlfq_scheduler_with_aging: PASSED **");
		else
			$display("** mlfq_scheduler_with_aging: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/mlfq_pkg.sv
rtl/core/mlfq_if.sv
rtl/core/mlfq_dpath.sv
rtl/core/mlfq_ctrl.sv
rtl/core/mlfq_scheduler_with_aging.sv
test/tb_mlfq_scheduler_with_aging.sv
